// File: hdl/i2cm_pkg.sv
// shared types and constants for the i2c eeprom byte access master
// no dependencies
`default_nettype none

package i2cm_pkg;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int DEV_ADDR_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

    // configuration reset values
    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd80;
    localparam logic [BYTE_W-1:0]     ACK_WAIT_RST = 8'd250;

    // one result word of the sequencer
    typedef struct packed {
        logic              nack_seen;
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_level;
        logic              scl_level;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/i2c_eeprom_byte_access_master.sv
// top level of the i2c eeprom byte access master
// depends on i2cm_pkg, i2cm_seq, i2cm_out_reg
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+---------------------------------------
//  s stream  | in        | s_tvalid / s_tready   | tuser: command; tdata: addr, data, sda
//  m stream  | out       | m_tvalid / m_tready   | tdata: scl, sda, busy, done, rd, nack
//  cfg write | in        | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// every accepted word is one bus tick and yields one result word, registered for the m side in the next cycle
// the sequencer steps once per accepted word, so a word can be taken every cycle while the output register has room
// the output register keeps accepting while its word is taken in the same cycle
// a stall on the m side holds s_tready low once the output register is full
// synchronous active-low reset: idle, both lines released, device address 80, ack limit 250
`default_nettype none

module i2c_eeprom_byte_access_master (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [7:0] word_address, [15:8] write_data, [16] sda_in
    input  wire  [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [11:4] read_byte, [12] nack_seen
    // configuration writes
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data
);

    logic               accept;
    logic               room;
    i2cm_pkg::t_result  seq_result;
    i2cm_pkg::t_result  out_result;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // sequencer advances one bus phase per accepted word
    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_cmd       (s_tuser),
        .i_word_addr (s_tdata[7:0]),
        .i_wdata     (s_tdata[15:8]),
        .i_sda_in    (s_tdata[16]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_result    (seq_result)
    );

    // result register toward the m side
    i2cm_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (seq_result),
        .i_take   (m_tready),
        .o_valid  (m_tvalid),
        .o_room   (room),
        .o_result (out_result)
    );

    // pack result fields, lowest first, padded to two bytes
    assign m_tdata = {3'b000,
                      out_result.nack_seen,
                      out_result.read_byte,
                      out_result.done_res,
                      out_result.busy_res,
                      out_result.sda_level,
                      out_result.scl_level};

endmodule

`default_nettype wire

// File: hdl/i2cm_seq.sv
// bus phase sequencer: config registers, transfer state and one-tick next-state logic
// depends on i2cm_pkg
`default_nettype none

module i2cm_seq (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_step,
    input  wire [i2cm_pkg::CMD_W-1:0]      i_cmd,
    input  wire [i2cm_pkg::BYTE_W-1:0]     i_word_addr,
    input  wire [i2cm_pkg::BYTE_W-1:0]     i_wdata,
    input  wire                            i_sda_in,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_idx,
    input  wire [i2cm_pkg::BYTE_W-1:0]     i_cfg_data,
    output i2cm_pkg::t_result              o_result
);

    typedef enum logic [3:0] {
        S_IDLE        = 4'd0,
        S_START_SETUP = 4'd1,
        S_START_FALL  = 4'd2,
        S_START_LOW   = 4'd3,
        S_TX_LOW      = 4'd4,
        S_TX_HIGH     = 4'd5,
        S_TX_REL      = 4'd6,
        S_ACK_POLL    = 4'd7,
        S_ACK_END     = 4'd8,
        S_RX_LOW      = 4'd9,
        S_RX_HIGH     = 4'd10,
        S_MNACK_LOW   = 4'd11,
        S_MNACK_HIGH  = 4'd12,
        S_STOP_LOW    = 4'd13,
        S_STOP_RISE   = 4'd14,
        S_STOP_END    = 4'd15
    } t_step;

    // byte stage within a transfer
    localparam logic [1:0] STG_DEV  = 2'd0;
    localparam logic [1:0] STG_ADDR = 2'd1;
    localparam logic [1:0] STG_DATA = 2'd2;
    localparam logic [1:0] STG_RX   = 2'd3;

    t_step                            r_step,       n_step;
    logic [1:0]                       r_stage,      n_stage;
    logic [3:0]                       r_bit_cnt,    n_bit_cnt;
    logic [i2cm_pkg::BYTE_W-1:0]      r_shift,      n_shift;
    logic [i2cm_pkg::BYTE_W-1:0]      r_ack_cnt,    n_ack_cnt;
    logic [i2cm_pkg::CMD_W-1:0]       r_held_cmd,   n_held_cmd;
    logic [i2cm_pkg::BYTE_W-1:0]      r_held_addr,  n_held_addr;
    logic [i2cm_pkg::BYTE_W-1:0]      r_held_data,  n_held_data;
    logic                             r_nack,       n_nack;
    logic [i2cm_pkg::BYTE_W-1:0]      r_read_byte,  n_read_byte;
    logic [i2cm_pkg::DEV_ADDR_W-1:0]  r_dev_addr;
    logic [i2cm_pkg::BYTE_W-1:0]      r_ack_limit;

    logic                             scl, sda, busy, done;
    logic [3:0]                       bit_inc;
    logic [i2cm_pkg::BYTE_W:0]        ack_inc;
    logic                             bitv;

    assign bitv    = r_shift[i2cm_pkg::BYTE_W-1];
    assign bit_inc = r_bit_cnt + 4'd1;
    assign ack_inc = {1'b0, r_ack_cnt} + {{i2cm_pkg::BYTE_W{1'b0}}, 1'b1};

    always_comb begin
        n_step      = r_step;
        n_stage     = r_stage;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_ack_cnt   = r_ack_cnt;
        n_held_cmd  = r_held_cmd;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_nack      = r_nack;
        n_read_byte = r_read_byte;
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;

        unique case (r_step)
            S_IDLE: begin
                if (i_cmd == i2cm_pkg::CMD_WRITE || i_cmd == i2cm_pkg::CMD_READ) begin
                    n_held_cmd  = i_cmd;
                    n_held_addr = i_word_addr;
                    n_held_data = i_wdata;
                    n_nack      = 1'b0;
                    n_stage     = STG_DEV;
                    n_step      = S_START_FALL;
                end else begin
                    busy    = 1'b0;
                    n_stage = STG_DEV;
                end
            end
            S_START_SETUP: n_step = S_START_FALL;
            S_START_FALL: begin
                sda    = 1'b0;
                n_step = S_START_LOW;
            end
            S_START_LOW: begin
                scl       = 1'b0;
                sda       = 1'b0;
                // read direction bit once past the address bytes
                n_shift   = {r_dev_addr, r_stage[1]};
                n_bit_cnt = 4'd0;
                n_step    = S_TX_LOW;
            end
            S_TX_LOW: begin
                scl    = 1'b0;
                sda    = bitv;
                n_step = S_TX_HIGH;
            end
            S_TX_HIGH: begin
                sda       = bitv;
                n_shift   = {r_shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
                n_bit_cnt = bit_inc;
                n_step    = (bit_inc >= 4'd8) ? S_TX_REL : S_TX_LOW;
            end
            S_TX_REL: begin
                scl       = 1'b0;
                n_ack_cnt = '0;
                n_step    = S_ACK_POLL;
            end
            S_ACK_POLL: begin
                if (!i_sda_in) begin
                    n_step = S_ACK_END;
                end else begin
                    n_ack_cnt = ack_inc[i2cm_pkg::BYTE_W-1:0];
                    if (ack_inc >= {1'b0, r_ack_limit}) begin
                        n_nack = 1'b1;
                        n_step = S_ACK_END;
                    end
                end
            end
            S_ACK_END: begin
                scl = 1'b0;
                if (r_stage == STG_DEV) begin
                    n_shift   = r_held_addr;
                    n_bit_cnt = 4'd0;
                    n_stage   = STG_ADDR;
                    n_step    = S_TX_LOW;
                end else if (r_stage == STG_ADDR) begin
                    n_stage = STG_DATA;
                    if (r_held_cmd == i2cm_pkg::CMD_READ) begin
                        n_step = S_START_SETUP;
                    end else begin
                        n_shift   = r_held_data;
                        n_bit_cnt = 4'd0;
                        n_step    = S_TX_LOW;
                    end
                end else if (r_stage == STG_DATA && r_held_cmd == i2cm_pkg::CMD_READ) begin
                    n_shift   = '0;
                    n_bit_cnt = 4'd0;
                    n_stage   = STG_RX;
                    n_step    = S_RX_LOW;
                end else begin
                    n_step = S_STOP_LOW;
                end
            end
            S_RX_LOW: begin
                scl    = 1'b0;
                n_step = S_RX_HIGH;
            end
            S_RX_HIGH: begin
                n_shift   = {r_shift[i2cm_pkg::BYTE_W-2:0], i_sda_in};
                n_bit_cnt = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_read_byte = {r_shift[i2cm_pkg::BYTE_W-2:0], i_sda_in};
                    n_step      = S_MNACK_LOW;
                end else begin
                    n_step = S_RX_LOW;
                end
            end
            S_MNACK_LOW: begin
                scl    = 1'b0;
                n_step = S_MNACK_HIGH;
            end
            S_MNACK_HIGH: n_step = S_STOP_LOW;
            S_STOP_LOW: begin
                scl    = 1'b0;
                sda    = 1'b0;
                n_step = S_STOP_RISE;
            end
            S_STOP_RISE: begin
                sda    = 1'b0;
                n_step = S_STOP_END;
            end
            S_STOP_END: begin
                done    = 1'b1;
                n_stage = STG_DEV;
                n_step  = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.scl_level = scl;
        o_result.sda_level = sda;
        o_result.busy_res  = busy;
        o_result.done_res  = done;
        o_result.read_byte = n_read_byte;
        o_result.nack_seen = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_stage     <= STG_DEV;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_ack_cnt   <= '0;
            r_held_cmd  <= i2cm_pkg::CMD_NONE;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_nack      <= 1'b0;
            r_read_byte <= '0;
            r_dev_addr  <= i2cm_pkg::DEV_ADDR_RST;
            r_ack_limit <= i2cm_pkg::ACK_WAIT_RST;
        end else begin
            if (i_step) begin
                r_step      <= n_step;
                r_stage     <= n_stage;
                r_bit_cnt   <= n_bit_cnt;
                r_shift     <= n_shift;
                r_ack_cnt   <= n_ack_cnt;
                r_held_cmd  <= n_held_cmd;
                r_held_addr <= n_held_addr;
                r_held_data <= n_held_data;
                r_nack      <= n_nack;
                r_read_byte <= n_read_byte;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    i2cm_pkg::CFG_DEVICE_ADDRESS:
                        r_dev_addr <= i_cfg_data[i2cm_pkg::DEV_ADDR_W-1:0];
                    i2cm_pkg::CFG_ACK_WAIT_LIMIT:
                        r_ack_limit <= i_cfg_data;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/i2cm_out_reg.sv
// output register for result words, decouples downstream stalls from the sequencer
// depends on i2cm_pkg
`default_nettype none

module i2cm_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire i2cm_pkg::t_result  i_result,
    input  wire                     i_take,
    output logic                    o_valid,
    output logic                    o_room,
    output i2cm_pkg::t_result       o_result
);

    logic               r_valid;
    i2cm_pkg::t_result  r_result;

    // room when empty or when the held word leaves this cycle
    assign o_room   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
